@@ rtl/slt_pkg.sv @@
// Shared constants, codes and types of the sorted list table.
`default_nettype none

package slt_pkg;

	// Number of entries the table holds.
	localparam int DEPTH = 16;
	// Width of the fill count, able to hold DEPTH itself.
	localparam int CNT_W = $clog2(DEPTH + 1);
	// Fixed widths of the channel fields.
	localparam int OP_W = 2;
	localparam int KEY_W = 32;
	localparam int ST_W = 2;
	localparam int ENTRY_W = 5;
	// Depth of the command queue between the front and the back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} st_t;

	// A classified command as the front hands it to the back.
	typedef struct packed {
		logic                    is_insert;
		logic                    is_lookup;
		logic                    is_remove;
		logic                    is_pop;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

endpackage

`default_nettype wire

@@ rtl/slt_req_if.sv @@
// Request channel: operation and key value with a valid/ready handshake.
`default_nettype none

interface slt_req_if;
	import slt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [OP_W-1:0]               operation;
	logic signed [KEY_W-1:0]       key_value;

	modport source (output valid, output operation, output key_value, input ready);
	modport sink (input valid, input operation, input key_value, output ready);
endinterface

`default_nettype wire

@@ rtl/slt_rsp_if.sv @@
// Response channel: status, popped value and entry count with a valid/ready handshake.
`default_nettype none

interface slt_rsp_if;
	import slt_pkg::*;

	logic                          valid;
	logic                          ready;
	logic [ST_W-1:0]               status;
	logic signed [KEY_W-1:0]       popped_value;
	logic [ENTRY_W-1:0]            entry_count;

	modport source (output valid, output status, output popped_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input popped_value, input entry_count,
		output ready);
endinterface

`default_nettype wire

@@ rtl/slt_front.sv @@
// Front end: takes request beats, decodes the operation and registers the command.
`default_nettype none

module slt_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	slt_req_if.sink             req,
	output slt_pkg::cmd_t       cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);
	import slt_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t decoded;
	logic take;

	// The stage takes a new beat when it is empty or its command moves on.
	assign req.ready = !valid_s1 || cmd_ready;
	assign take = req.valid && req.ready;

	// Classify the operation into the flags the back end acts on.
	always_comb begin
		decoded = '0;
		decoded.key = req.key_value;
		unique case (op_t'(req.operation))
			OP_INSERT: decoded.is_insert = 1'b1;
			OP_SEARCH: decoded.is_lookup = 1'b1;
			OP_DELETE: begin
				decoded.is_lookup = 1'b1;
				decoded.is_remove = 1'b1;
			end
			OP_POP:    decoded.is_pop = 1'b1;
		endcase
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= decoded;
		end
	end

	assign cmd = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

`default_nettype wire

@@ rtl/slt_queue.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module slt_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire slt_pkg::cmd_t  push_cmd,
	input  wire logic           push_valid,
	output logic                push_ready,
	output slt_pkg::cmd_t       pop_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready
);
	import slt_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q < QCNT_W'(QDEPTH);
	assign pop_valid = count_q != '0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;
	assign pop_cmd = slot_q[rd_ptr_q];

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Slot storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

@@ rtl/slt_back.sv @@
// Back end: row of compare-and-shift cells holding the sorted entries, plus the result register.
`default_nettype none

module slt_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire slt_pkg::cmd_t  cmd,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	slt_rsp_if.source           rsp
);
	import slt_pkg::*;

	logic signed [KEY_W-1:0] entry_q [DEPTH];
	logic [CNT_W-1:0]        cnt_q;
	logic                    out_valid_q;
	st_t                     status_q;
	logic signed [KEY_W-1:0] popped_q;
	logic [CNT_W-1:0]        cnt_out_q;

	logic [DEPTH-1:0]        ge;
	logic [DEPTH-1:0]        ge_prev;
	logic [DEPTH-1:0]        match;
	logic signed [KEY_W-1:0] up_val [DEPTH];
	logic signed [KEY_W-1:0] dn_val [DEPTH];
	logic signed [KEY_W-1:0] entry_d [DEPTH];

	logic fire;
	logic full;
	logic empty;
	logic found;
	logic do_ins;
	logic do_del;
	logic do_pop;
	st_t  status_d;
	logic [CNT_W-1:0] cnt_d;

	// A command executes when the result register is free or being drained.
	assign cmd_ready = !out_valid_q || rsp.ready;
	assign fire = cmd_valid && cmd_ready;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign found = |match;
	assign do_ins = cmd.is_insert && !full;
	assign do_del = cmd.is_remove && found;
	assign do_pop = cmd.is_pop && !empty;

	// Each cell compares its entry with the key and picks its next value locally.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic below;
		assign below = CNT_W'(g) < cnt_q;
		// Set for the cell at the insert point and every cell after it.
		assign ge[g] = !(below && (entry_q[g] < cmd.key));
		assign match[g] = below && (entry_q[g] == cmd.key);

		if (g == 0) begin : g_first
			assign ge_prev[g] = 1'b0;
			assign up_val[g] = cmd.key;
		end else begin : g_inner
			assign ge_prev[g] = ge[g-1];
			assign up_val[g] = entry_q[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign dn_val[g] = entry_q[g];
		end else begin : g_mid
			assign dn_val[g] = entry_q[g+1];
		end

		// Insert shifts up from the insert point; delete and pop shift down.
		always_comb begin
			entry_d[g] = entry_q[g];
			if (do_ins && ge[g]) begin
				entry_d[g] = ge_prev[g] ? up_val[g] : cmd.key;
			end else if ((do_del && ge[g]) || do_pop) begin
				entry_d[g] = dn_val[g];
			end
		end

		always_ff @(posedge clk) begin
			if (fire) begin
				entry_q[g] <= entry_d[g];
			end
		end
	end

	// Status and new count.
	always_comb begin
		status_d = ST_OK;
		cnt_d = cnt_q;
		if (cmd.is_insert) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end else if (cmd.is_lookup) begin
			if (!found) begin
				status_d = ST_NOT_FOUND;
			end else if (cmd.is_remove) begin
				cnt_d = cnt_q - 1'b1;
			end
		end else if (empty) begin
			status_d = ST_EMPTY;
		end else begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	// Fill count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				cnt_q <= cnt_d;
			end
			if (cmd_ready) begin
				out_valid_q <= cmd_valid;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			popped_q <= do_pop ? entry_q[0] : '0;
			cnt_out_q <= cnt_d;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = status_q;
	assign rsp.popped_value = popped_q;
	assign rsp.entry_count = ENTRY_W'(cnt_out_q);

endmodule

`default_nettype wire

@@ rtl/sorted_list_table.sv @@
// Top level of the sorted list table: front end, command queue and cell row.
//
//   Channel | Direction | Fields                                  | Handshake
//   req     | in        | operation, key_value                    | valid/ready
//   rsp     | out       | status, popped_value, entry_count       | valid/ready
//
// One operation is accepted per cycle while the response side keeps up.
// A request beat is registered in the front register, then in a queue slot,
// then in the result register behind the cell row, which works out every
// operation combinationally in front of that register.
// Reset empties the table and the queue; stored values are not cleared.
// A stalled response holds the cell row; the two-entry queue and the front
// register keep taking beats until they fill.
`default_nettype none

module sorted_list_table (
	input  wire logic  clk,
	input  wire logic  arst_n,
	slt_req_if.sink    req,
	slt_rsp_if.source  rsp
);
	import slt_pkg::*;

	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;
	cmd_t back_cmd;
	logic back_valid;
	logic back_ready;

	slt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	slt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (front_cmd),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_cmd    (back_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
